@@ sv/pfd_pkg.sv @@
package pfd_pkg;

    // Width of every value, to which each intermediate is saturated; the ports are fixed at this width.
    localparam int DATA_W    = 32;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

    localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Configuration register indexes.
    localparam cfg_idx_t CFG_PROP_GAIN   = 3'd0;
    localparam cfg_idx_t CFG_INTEG_GAIN  = 3'd1;
    localparam cfg_idx_t CFG_DERIV_GAIN  = 3'd2;
    localparam cfg_idx_t CFG_FILTER_TC   = 3'd3;
    localparam cfg_idx_t CFG_SAMPLE_PER  = 3'd4;
    localparam cfg_idx_t CFG_LIMIT_LOW   = 3'd5;
    localparam cfg_idx_t CFG_LIMIT_HIGH  = 3'd6;

    // Operation codes of an input transaction.
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] target;
        logic signed [31:0] sensed;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] drive;
    } out_item_t;

    // Request to the serial divider.
    typedef struct packed {
        logic              start;
        logic              short_mode;
        logic              neg;
        logic [DATA_W-1:0] num_mag;
        logic [DATA_W-1:0] den;
    } div_req_t;

endpackage

@@ sv/pfd_if.sv @@
interface pfd_in_if;
    logic               valid;
    logic               ready;
    pfd_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pfd_out_if;
    logic               valid;
    logic               ready;
    pfd_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/pfd_mul.sv @@
module pfd_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic           clk,
    input  pfd_pkg::data_t op_a,
    input  pfd_pkg::data_t op_b,
    output pfd_pkg::data_t result
);
    import pfd_pkg::*;

    localparam int PROD_W = 2 * DATA_W;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] shifted;
    logic [PROD_W-DATA_W:0]   upper;
    logic                     fits;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    // The arithmetic shift rounds toward minus infinity; then saturate.
    assign shifted = prod_reg >>> FRAC_BITS;
    assign upper   = shifted[PROD_W-1:DATA_W-1];
    assign fits    = (&upper) || (~|upper);
    assign result  = fits ? shifted[DATA_W-1:0]
                          : (shifted[PROD_W-1] ? DATA_MIN : DATA_MAX);

endmodule

@@ sv/pfd_div.sv @@
module pfd_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pfd_pkg::div_req_t req,
    output logic              busy,
    output pfd_pkg::data_t    quot
);
    import pfd_pkg::*;

    localparam int CNT_W = $clog2(DATA_W + 1);
    localparam logic [CNT_W-1:0] LONG_N  = CNT_W'(DATA_W);
    localparam logic [CNT_W-1:0] SHORT_N = CNT_W'(FRAC_BITS + 1);

    logic              busy_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] bits_reg;
    logic [DATA_W-1:0] q_reg;
    logic [DATA_W-1:0] den_reg;
    logic              neg_reg;
    data_t             quot_reg;

    logic [DATA_W-1:0] rem_init;
    logic [DATA_W-1:0] bits_init;
    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   rem_diff;
    logic              ge;
    data_t             signed_q;

    // The numerator is num_mag shifted up by FRAC_BITS. The short mode only
    // needs FRAC_BITS+1 quotient bits, as its quotient never exceeds one.
    assign rem_init  = req.short_mode ? (req.num_mag >> 1)
                                      : (req.num_mag >> (DATA_W - FRAC_BITS));
    assign bits_init = req.short_mode ? (req.num_mag << (DATA_W - 1))
                                      : (req.num_mag << FRAC_BITS);

    assign rem_shift = {rem_reg, bits_reg[DATA_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign ge        = !rem_diff[DATA_W];

    always_comb
    begin
        if (!neg_reg)
        begin
            signed_q = q_reg[DATA_W-1] ? DATA_MAX : data_t'(q_reg);
        end
        else if (q_reg[DATA_W-1] && (|q_reg[DATA_W-2:0]))
        begin
            signed_q = DATA_MIN;
        end
        else
        begin
            signed_q = data_t'(~q_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            if ((req.den != '0) && (rem_init < req.den))
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.short_mode ? SHORT_N : LONG_N;
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            else
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= rem_init;
            bits_reg <= bits_init;
            q_reg    <= '0;
            den_reg  <= req.den;
            neg_reg  <= req.neg;
            if (req.den == '0)
            begin
                quot_reg <= '0;
            end
            else if (rem_init >= req.den)
            begin
                quot_reg <= req.neg ? DATA_MIN : DATA_MAX;
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                rem_reg  <= ge ? rem_diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
                bits_reg <= bits_reg << 1;
                q_reg    <= {q_reg[DATA_W-2:0], ge};
            end
            else
            begin
                quot_reg <= signed_q;
            end
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

@@ sv/pid_filtered_derivative_step.sv @@
// One step of a fixed-point PID controller with a low-pass filtered derivative
// and an anti-windup integrator, all values signed with FRAC_BITS fraction bits
// and every intermediate saturated to 32 bits. A compute transaction
// (opcode 0) returns one drive value clamped to [limit_low, limit_high]; a clear
// transaction (opcode 1) zeroes the integrator, the previous error and the
// previous derivative and returns nothing. A compute transaction occupies the
// block from acceptance until the sequencer is back in idle, and no new
// transaction is taken before then; at the default FRAC_BITS values are Q16.16.
// That time is set chiefly by the shared radix-2 divider, which forms alpha and
// then beta, one after the other. The five multiplications share one registered
// 32 x 32 multiplier: the first three run alongside the first division, and
// the two that form the filtered derivative follow once beta is ready. The
// result sits in an output register, so the next transaction is taken while
// it waits to be collected. Configuration is written through cfg_we,
// cfg_index and cfg_data and must only change while the block is idle.
module pid_filtered_derivative_step #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pfd_pkg::DATA_W-1:0]      cfg_data,
    pfd_in_if.sink                          in_ch,
    pfd_out_if.source                       out_ch
);
    import pfd_pkg::*;

    // Reset values of the configuration: proportional gain 1.0, period 0.1, high limit 100.0.
    localparam longint ONE_Q      = longint'(1) << FRAC_BITS;
    localparam longint HI_FULL    = 100 * ONE_Q;
    localparam data_t  KP_RST     = data_t'(ONE_Q);
    localparam logic [DATA_W-2:0] DT_RST = (DATA_W-1)'((ONE_Q + 5) / 10);
    localparam data_t  HI_RST     = (HI_FULL > longint'(DATA_MAX)) ? DATA_MAX
                                                                   : data_t'(HI_FULL);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_ERR      = 12'b0000_0000_0010,
        S_MUL_KIDT = 12'b0000_0000_0100,
        S_MUL_P    = 12'b0000_0000_1000,
        S_MUL_I    = 12'b0000_0001_0000,
        S_INTEG    = 12'b0000_0010_0000,
        S_DIV_A    = 12'b0000_0100_0000,
        S_DIV_B    = 12'b0000_1000_0000,
        S_MUL_A    = 12'b0001_0000_0000,
        S_MUL_B    = 12'b0010_0000_0000,
        S_DERIV    = 12'b0100_0000_0000,
        S_SUM      = 12'b1000_0000_0000
    } state_t;

    // Saturating helpers on 33-bit exact results.
    function automatic data_t sat_wide(input logic [DATA_W:0] v);
        if (v[DATA_W] != v[DATA_W-1])
        begin
            return v[DATA_W] ? DATA_MIN : DATA_MAX;
        end
        return data_t'(v[DATA_W-1:0]);
    endfunction

    function automatic data_t sadd(input data_t a, input data_t b);
        return sat_wide({a[DATA_W-1], a} + {b[DATA_W-1], b});
    endfunction

    function automatic data_t ssub(input data_t a, input data_t b);
        return sat_wide({a[DATA_W-1], a} - {b[DATA_W-1], b});
    endfunction

    // The high limit is tested first, so inverted limits give limit_high
    // for values above it.
    function automatic data_t clamp(input data_t v, input data_t lo, input data_t hi);
        if (v > hi)
        begin
            return hi;
        end
        if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    // Configuration registers.
    data_t             kp_reg;
    data_t             ki_reg;
    data_t             kd_reg;
    logic [DATA_W-2:0] tau_reg;
    logic [DATA_W-2:0] dt_reg;
    data_t             lo_reg;
    data_t             hi_reg;

    // Control and loop state.
    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    data_t  integ_reg;
    data_t  last_error_reg;
    data_t  last_deriv_reg;

    // Working registers of one step.
    data_t target_reg;
    data_t sensed_reg;
    data_t err_reg;
    data_t dd_reg;
    data_t kidt_reg;
    data_t p_reg;
    data_t alpha_reg;
    data_t m1_reg;
    data_t pi_reg;
    data_t drive_reg;

    logic              in_fire;
    logic              slot_free;
    data_t             mul_a;
    data_t             mul_b;
    data_t             mul_res;
    div_req_t          div_req;
    logic              div_busy;
    data_t             div_quot;
    logic [DATA_W-1:0] den_sum;
    logic [DATA_W-1:0] kd_mag;

    assign in_fire   = in_ch.valid && in_ch.ready;
    assign slot_free = !out_valid_reg || out_ch.ready;

    assign in_ch.ready      = (state_reg == S_IDLE);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.data.drive = drive_reg;

    // ------------------------------------------------------------------
    // Configuration port. Indexes beyond the list are ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg  <= KP_RST;
            ki_reg  <= '0;
            kd_reg  <= '0;
            tau_reg <= '0;
            dt_reg  <= DT_RST;
            lo_reg  <= '0;
            hi_reg  <= HI_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PROP_GAIN:  kp_reg  <= data_t'(cfg_data);
                CFG_INTEG_GAIN: ki_reg  <= data_t'(cfg_data);
                CFG_DERIV_GAIN: kd_reg  <= data_t'(cfg_data);
                CFG_FILTER_TC:  tau_reg <= cfg_data[DATA_W-2:0];
                CFG_SAMPLE_PER: dt_reg  <= cfg_data[DATA_W-2:0];
                CFG_LIMIT_LOW:  lo_reg  <= data_t'(cfg_data);
                CFG_LIMIT_HIGH: hi_reg  <= data_t'(cfg_data);
                default:        ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier. Its product is registered, so a result is taken
    // one state after its operands were presented.
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_MUL_KIDT:
            begin
                mul_a = ki_reg;
                mul_b = data_t'({1'b0, dt_reg});
            end
            S_MUL_P:
            begin
                mul_a = kp_reg;
                mul_b = err_reg;
            end
            S_MUL_I:
            begin
                mul_a = kidt_reg;
                mul_b = err_reg;
            end
            S_MUL_A:
            begin
                mul_a = alpha_reg;
                mul_b = last_deriv_reg;
            end
            S_MUL_B:
            begin
                mul_a = div_quot;
                mul_b = dd_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pfd_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk    (clk),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .result (mul_res)
    );

    // ------------------------------------------------------------------
    // Serial divider: alpha = tau / (tau + dt) is started as the error is
    // formed, beta = kd / (tau + dt) once alpha is collected.
    // ------------------------------------------------------------------
    assign den_sum = {1'b0, tau_reg} + {1'b0, dt_reg};
    assign kd_mag  = kd_reg[DATA_W-1] ? (~kd_reg + 1'b1) : kd_reg;

    always_comb
    begin
        div_req.start      = (state_reg == S_ERR) || ((state_reg == S_DIV_A) && !div_busy);
        div_req.short_mode = (state_reg == S_ERR);
        div_req.neg        = (state_reg == S_ERR) ? 1'b0 : kd_reg[DATA_W-1];
        div_req.num_mag    = (state_reg == S_ERR) ? {1'b0, tau_reg} : kd_mag;
        div_req.den        = den_sum;
    end

    pfd_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && (in_ch.data.opcode == OP_STEP))
                begin
                    state_next = S_ERR;
                end
            end
            S_ERR:      state_next = S_MUL_KIDT;
            S_MUL_KIDT: state_next = S_MUL_P;
            S_MUL_P:    state_next = S_MUL_I;
            S_MUL_I:    state_next = S_INTEG;
            S_INTEG:    state_next = S_DIV_A;
            S_DIV_A:
            begin
                if (!div_busy)
                begin
                    state_next = S_DIV_B;
                end
            end
            S_DIV_B:
            begin
                if (!div_busy)
                begin
                    state_next = S_MUL_A;
                end
            end
            S_MUL_A:    state_next = S_MUL_B;
            S_MUL_B:    state_next = S_DERIV;
            S_DERIV:    state_next = S_SUM;
            S_SUM:
            begin
                // Wait here while the previous result is still uncollected.
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Control state and the loop state that survives between steps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            integ_reg      <= '0;
            last_error_reg <= '0;
            last_deriv_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_SUM) && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_fire && (in_ch.data.opcode == OP_CLEAR))
            begin
                integ_reg      <= '0;
                last_error_reg <= '0;
                last_deriv_reg <= '0;
            end
            if (state_reg == S_INTEG)
            begin
                // Anti-windup: the accumulator is held within the output limits.
                integ_reg <= clamp(sadd(integ_reg, mul_res), lo_reg, hi_reg);
            end
            if (state_reg == S_DERIV)
            begin
                last_error_reg <= err_reg;
                last_deriv_reg <= sadd(m1_reg, mul_res);
            end
        end
    end

    // Datapath registers of the current step.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            target_reg <= data_t'(in_ch.data.target);
            sensed_reg <= data_t'(in_ch.data.sensed);
        end
        case (state_reg)
            S_ERR:      err_reg  <= ssub(target_reg, sensed_reg);
            S_MUL_KIDT: dd_reg   <= ssub(err_reg, last_error_reg);
            S_MUL_P:    kidt_reg <= mul_res;
            S_MUL_I:    p_reg    <= mul_res;
            S_DIV_A:
            begin
                if (!div_busy)
                begin
                    alpha_reg <= div_quot;
                end
            end
            S_MUL_B:    m1_reg   <= mul_res;
            S_DERIV:    pi_reg   <= sadd(p_reg, integ_reg);
            S_SUM:
            begin
                // The new derivative is already in last_deriv_reg here.
                if (slot_free)
                begin
                    drive_reg <= clamp(sadd(pi_reg, last_deriv_reg), lo_reg, hi_reg);
                end
            end
            default:    ;
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_clear_zeroes_state: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (in_ch.data.opcode == OP_CLEAR)) |=>
        ((integ_reg == '0) && (last_error_reg == '0) && (last_deriv_reg == '0)))
        else $error("loop state not cleared after a clear transaction");

    a_result_from_sum: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_SUM))
        else $error("result presented outside the final summing state");

    a_integ_within_limits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_INTEG) && (lo_reg <= hi_reg) && !cfg_we) |=>
        ((integ_reg >= $past(lo_reg)) && (integ_reg <= $past(hi_reg))))
        else $error("integrator left the output limits");

    a_div_done_before_use: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL_A) |-> !div_busy)
        else $error("beta used before the divider finished");

endmodule
